FILE: sv/utf8_dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// Shared types and constants for the six-byte UTF-8 sequence decoder.
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned CP_W     = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIX_W    = 6;
  localparam int unsigned MAX_LEN  = 6;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LEAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CONT = 2'd2;

  // sequence lengths
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
  localparam logic [LEN_W-1:0] LEN_5    = 3'd5;
  localparam logic [LEN_W-1:0] LEN_6    = 3'd6;

  // continuation byte form 10xxxxxx
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
  localparam logic [BYTE_W-1:0] CONT_MATCH = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_0;
    logic [BYTE_W-1:0] byte_1;
    logic [BYTE_W-1:0] byte_2;
    logic [BYTE_W-1:0] byte_3;
    logic [BYTE_W-1:0] byte_4;
    logic [BYTE_W-1:0] byte_5;
    logic [LEN_W-1:0]  avail_bytes;
  } window_t;

  typedef struct packed {
    logic [CP_W-1:0]     code_point;
    logic [LEN_W-1:0]    seq_length;
    logic [STATUS_W-1:0] status;
  } result_t;

  // sequence length selected by the lead byte, zero for a bad lead
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    len = LEN_NONE;
    if      ((b & 8'h80) == 8'h00) len = LEN_1;
    else if ((b & 8'he0) == 8'hc0) len = LEN_2;
    else if ((b & 8'hf0) == 8'he0) len = LEN_3;
    else if ((b & 8'hf8) == 8'hf0) len = LEN_4;
    else if ((b & 8'hfc) == 8'hf8) len = LEN_5;
    else if ((b & 8'hfe) == 8'hfc) len = LEN_6;
    return len;
  endfunction

  // payload bits of the lead byte for a given length
  function automatic logic [BYTE_W-2:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                     input logic [LEN_W-1:0]  len);
    logic [BYTE_W-2:0] p;
    case (len)
      LEN_1:   p = b[6:0] & 7'h7f;
      LEN_2:   p = b[6:0] & 7'h1f;
      LEN_3:   p = b[6:0] & 7'h0f;
      LEN_4:   p = b[6:0] & 7'h07;
      LEN_5:   p = b[6:0] & 7'h03;
      default: p = b[6:0] & 7'h01;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/utf8_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sequence_decoder_unit
// Decodes one code point per transaction from a six-byte window.
// ----------------------------------------------------------------------------
// Takes a window of up to six bytes plus a count of valid bytes and decodes
// one code point in the original UTF-8 form (sequences of one to six bytes).
// A bad lead byte (10xxxxxx, 0xfe, 0xff) or a window shorter than the lead
// byte asks for gives status 1 with zero length; a following byte inside the
// sequence that is not 10xxxxxx gives status 2 with the lead's length. The
// code point is zero on either error; overlong forms and surrogates pass.
// The datapath is three register stages (lead decode, error classify, code
// point assembly); a new transaction is taken every cycle while the result
// side does not stall. Any stall on the result side backs up through the
// stages without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module utf8_sequence_decoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  window_valid,
  output logic                  window_ready,
  input  utf8_dec_pkg::window_t window,
  output logic                  result_valid,
  input  logic                  result_ready,
  output utf8_dec_pkg::result_t result
);

  localparam int unsigned NCONT = utf8_dec_pkg::MAX_LEN - 1;
  localparam int unsigned ASM_W = (utf8_dec_pkg::BYTE_W - 1)
                                  + NCONT * utf8_dec_pkg::SIX_W;

  // stage 1: lead decode
  logic                                s1_valid;
  logic [utf8_dec_pkg::LEN_W-1:0]      s1_len;
  logic [utf8_dec_pkg::LEN_W-1:0]      s1_avail;
  logic [NCONT-1:0]                    s1_cont_ok;
  logic [utf8_dec_pkg::BYTE_W-2:0]     s1_lead;
  logic [NCONT-1:0][utf8_dec_pkg::SIX_W-1:0] s1_six;

  // stage 2: error classify
  logic                                s2_valid;
  logic [utf8_dec_pkg::LEN_W-1:0]      s2_len;
  logic [utf8_dec_pkg::STATUS_W-1:0]   s2_status;
  logic [utf8_dec_pkg::BYTE_W-2:0]     s2_lead;
  logic [NCONT-1:0][utf8_dec_pkg::SIX_W-1:0] s2_six;

  // stage 3 is the output register
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready     = !result_valid || result_ready;
  assign s2_ready     = !s2_valid || s3_ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign window_ready = s1_ready;

  // ---- stage 1 combinational: lead length, saturated count, cont checks ----
  logic [utf8_dec_pkg::BYTE_W-1:0]  in_bytes [NCONT];
  logic [utf8_dec_pkg::LEN_W-1:0]   len_next;
  logic [utf8_dec_pkg::LEN_W-1:0]   avail_next;
  logic [NCONT-1:0]                 cont_ok_next;
  logic [NCONT-1:0][utf8_dec_pkg::SIX_W-1:0] six_next;

  assign in_bytes[0] = window.byte_1;
  assign in_bytes[1] = window.byte_2;
  assign in_bytes[2] = window.byte_3;
  assign in_bytes[3] = window.byte_4;
  assign in_bytes[4] = window.byte_5;

  always_comb begin
    len_next   = utf8_dec_pkg::lead_length(window.byte_0);
    // a count of seven acts as six
    avail_next = (window.avail_bytes > utf8_dec_pkg::LEN_6) ? utf8_dec_pkg::LEN_6
                                                             : window.avail_bytes;
    for (int p = 0; p < NCONT; p++) begin
      cont_ok_next[p] = ((in_bytes[p] & utf8_dec_pkg::CONT_MASK)
                         == utf8_dec_pkg::CONT_MATCH);
      six_next[p]     = in_bytes[p][utf8_dec_pkg::SIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= window_valid;
    end
    if (s1_ready && window_valid) begin
      s1_len     <= len_next;
      s1_avail   <= avail_next;
      s1_cont_ok <= cont_ok_next;
      s1_lead    <= utf8_dec_pkg::lead_payload(window.byte_0, len_next);
      s1_six     <= six_next;
    end
  end

  // ---- stage 2 combinational: classify errors ----
  logic                              cont_bad;
  logic                              lead_bad;
  logic [utf8_dec_pkg::LEN_W-1:0]    s2_len_next;
  logic [utf8_dec_pkg::STATUS_W-1:0] s2_status_next;

  always_comb begin
    cont_bad = 1'b0;
    // only bytes inside the sequence are checked
    for (int p = 0; p < NCONT; p++) begin
      if ((s1_len > utf8_dec_pkg::LEN_W'(p + 1)) && !s1_cont_ok[p]) begin
        cont_bad = 1'b1;
      end
    end
    lead_bad = (s1_len == utf8_dec_pkg::LEN_NONE) || (s1_avail < s1_len);
    if (lead_bad) begin
      s2_len_next    = utf8_dec_pkg::LEN_NONE;
      s2_status_next = utf8_dec_pkg::STATUS_BAD_LEAD;
    end else if (cont_bad) begin
      s2_len_next    = s1_len;
      s2_status_next = utf8_dec_pkg::STATUS_BAD_CONT;
    end else begin
      s2_len_next    = s1_len;
      s2_status_next = utf8_dec_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_len    <= s2_len_next;
      s2_status <= s2_status_next;
      s2_lead   <= s1_lead;
      s2_six    <= s1_six;
    end
  end

  // ---- stage 3 combinational: assemble the code point ----
  logic [ASM_W-1:0]  assembled;
  utf8_dec_pkg::result_t result_next;

  always_comb begin
    case (s2_len)
      utf8_dec_pkg::LEN_1: assembled = ASM_W'(s2_lead);
      utf8_dec_pkg::LEN_2: assembled = ASM_W'({s2_lead, s2_six[0]});
      utf8_dec_pkg::LEN_3: assembled = ASM_W'({s2_lead, s2_six[0], s2_six[1]});
      utf8_dec_pkg::LEN_4: assembled = ASM_W'({s2_lead, s2_six[0], s2_six[1],
                                               s2_six[2]});
      utf8_dec_pkg::LEN_5: assembled = ASM_W'({s2_lead, s2_six[0], s2_six[1],
                                               s2_six[2], s2_six[3]});
      utf8_dec_pkg::LEN_6: assembled = {s2_lead, s2_six[0], s2_six[1],
                                        s2_six[2], s2_six[3], s2_six[4]};
      default:             assembled = '0;
    endcase
    result_next.code_point = (s2_status == utf8_dec_pkg::STATUS_OK)
                             ? assembled[utf8_dec_pkg::CP_W-1:0] : '0;
    result_next.seq_length = s2_len;
    result_next.status     = s2_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_ready) begin
      result_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      result <= result_next;
    end
  end

  // ---- assertions ----
  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != utf8_dec_pkg::STATUS_OK) |-> result.code_point == '0)
    else $error("code point not zero on error");

  a_bad_lead_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == utf8_dec_pkg::STATUS_BAD_LEAD)
    |-> result.seq_length == utf8_dec_pkg::LEN_NONE)
    else $error("bad lead with nonzero length");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != utf8_dec_pkg::STATUS_BAD_LEAD)
    |-> result.seq_length != utf8_dec_pkg::LEN_NONE)
    else $error("good lead with zero length");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_len))
    else $error("stage 1 lost a stalled transaction");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_ready |=> s2_valid && $stable(s2_status))
    else $error("stage 2 lost a stalled transaction");

endmodule

FILE: tb/sv/tb_utf8_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_sequence_decoder_unit
// Self-checking bench for the six-byte UTF-8 sequence decoder.
// ----------------------------------------------------------------------------
// Windows go in over a valid/ready channel. Each accepted transaction is
// decoded by a behavioral decoder in the bench, and the result is queued.
// Every result transaction that leaves the unit is checked field by field
// against the oldest queued result. Directed windows cover the length
// extremes, bad lead bytes, short windows and bad continuation bytes. Random
// windows are mostly well-formed sequences with random payload, plus broken
// and noise windows. Both sides stall at random in two mixes, then run
// without stalls.
// ----------------------------------------------------------------------------
module tb_utf8_sequence_decoder_unit;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS  = 533;
  localparam int unsigned PRINT_LIMIT  = 40;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  window_valid;
  logic                  window_ready;
  utf8_dec_pkg::window_t window;
  logic                  result_valid;
  logic                  result_ready;
  utf8_dec_pkg::result_t result;

  // decoded results waiting for their transaction from the unit
  utf8_dec_pkg::result_t decoded_queue[$];
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  // stall odds in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  utf8_sequence_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .window_valid (window_valid),
    .window_ready (window_ready),
    .window       (window),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // behavioral decoder
  // --------------------------------------------------------------------------
  function automatic utf8_dec_pkg::result_t decode_window(input utf8_dec_pkg::window_t w);
    logic [utf8_dec_pkg::BYTE_W-1:0] octet [utf8_dec_pkg::MAX_LEN];
    logic [utf8_dec_pkg::LEN_W-1:0]  avail;
    logic [utf8_dec_pkg::LEN_W-1:0]  n;
    logic [31:0]                     cp;
    utf8_dec_pkg::result_t           r;
    octet[0] = w.byte_0;
    octet[1] = w.byte_1;
    octet[2] = w.byte_2;
    octet[3] = w.byte_3;
    octet[4] = w.byte_4;
    octet[5] = w.byte_5;
    // a count of seven means a full window
    avail = (w.avail_bytes > utf8_dec_pkg::LEN_6) ? utf8_dec_pkg::LEN_6 : w.avail_bytes;
    if (octet[0] inside {[8'h00:8'h7f]})      n = utf8_dec_pkg::LEN_1;
    else if (octet[0] inside {[8'hc0:8'hdf]}) n = utf8_dec_pkg::LEN_2;
    else if (octet[0] inside {[8'he0:8'hef]}) n = utf8_dec_pkg::LEN_3;
    else if (octet[0] inside {[8'hf0:8'hf7]}) n = utf8_dec_pkg::LEN_4;
    else if (octet[0] inside {[8'hf8:8'hfb]}) n = utf8_dec_pkg::LEN_5;
    else if (octet[0] inside {[8'hfc:8'hfd]}) n = utf8_dec_pkg::LEN_6;
    else                                      n = utf8_dec_pkg::LEN_NONE;
    r.code_point = '0;
    r.seq_length = utf8_dec_pkg::LEN_NONE;
    r.status     = utf8_dec_pkg::STATUS_BAD_LEAD;
    // bad lead or too few bytes in the window
    if (n == utf8_dec_pkg::LEN_NONE || avail < n) return r;
    r.seq_length = n;
    // lead payload: everything below the first zero bit of the prefix
    cp = 32'(octet[0] & (8'hff >> ((n == utf8_dec_pkg::LEN_1) ? 1 : n + 1)));
    for (int p = 1; p < utf8_dec_pkg::MAX_LEN; p++) begin
      if (p < n) begin
        if ((octet[p] & utf8_dec_pkg::CONT_MASK) != utf8_dec_pkg::CONT_MATCH) begin
          r.status = utf8_dec_pkg::STATUS_BAD_CONT;
          return r;
        end
        cp = {cp[25:0], octet[p][5:0]};
      end
    end
    r.code_point = cp[utf8_dec_pkg::CP_W-1:0];
    r.status     = utf8_dec_pkg::STATUS_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns  mismatch on %s: got %0h, want %0h", $time, what, got, want);
    error_count++;
  endtask

  // input side is recorded before the output side is checked, so the
  // order of the two within one edge never matters
  always @(posedge clk) begin : scoreboard
    utf8_dec_pkg::result_t want;
    if (!rst) begin
      if (window_valid && window_ready)
        decoded_queue.push_back(decode_window(window));
      if (result_valid && result_ready) begin
        if (decoded_queue.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(result), '0);
        end else begin
          want = decoded_queue.pop_front();
          if (result.code_point !== want.code_point)
            report_mismatch("code_point", 64'(result.code_point), 64'(want.code_point));
          if (result.seq_length !== want.seq_length)
            report_mismatch("seq_length", 64'(result.seq_length), 64'(want.seq_length));
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (window_valid && window_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_utf8_sequence_decoder_unit: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  // one window transaction, with random sender gaps ahead of it; returns
  // at the edge where it is accepted
  task automatic send_window(input utf8_dec_pkg::window_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      window_valid <= 1'b0;
      @(posedge clk);
    end
    window_valid <= 1'b1;
    window       <= w;
    @(posedge clk);
    while (!window_ready) @(posedge clk);
  endtask

  function automatic utf8_dec_pkg::window_t make_window(input logic [7:0] b0, b1, b2, b3,
                                                        b4, b5,
                                                        input logic [2:0] avail);
    utf8_dec_pkg::window_t w;
    w.byte_0      = b0;
    w.byte_1      = b1;
    w.byte_2      = b2;
    w.byte_3      = b3;
    w.byte_4      = b4;
    w.byte_5      = b5;
    w.avail_bytes = avail;
    return w;
  endfunction

  // mostly well-formed sequences, then bad continuations, short windows
  // and pure noise
  function automatic utf8_dec_pkg::window_t random_window();
    logic [utf8_dec_pkg::BYTE_W-1:0] octet [utf8_dec_pkg::MAX_LEN];
    logic [utf8_dec_pkg::LEN_W-1:0]  avail;
    int unsigned                     kind;
    int unsigned                     len;
    int unsigned                     pos;
    kind = $urandom_range(99, 0);
    len  = $urandom_range(6, 1);
    case (len)
      1:       octet[0] = 8'($urandom) & 8'h7f;
      2:       octet[0] = 8'hc0 | (8'($urandom) & 8'h1f);
      3:       octet[0] = 8'he0 | (8'($urandom) & 8'h0f);
      4:       octet[0] = 8'hf0 | (8'($urandom) & 8'h07);
      5:       octet[0] = 8'hf8 | (8'($urandom) & 8'h03);
      default: octet[0] = 8'hfc | (8'($urandom) & 8'h01);
    endcase
    for (int p = 1; p < utf8_dec_pkg::MAX_LEN; p++)
      octet[p] = (p < len) ? (utf8_dec_pkg::CONT_MATCH | (8'($urandom) & 8'h3f))
                           : 8'($urandom);
    avail = 3'($urandom_range(7, len));
    if (kind < 15) begin
      // noise
      for (int p = 0; p < utf8_dec_pkg::MAX_LEN; p++) octet[p] = 8'($urandom);
      avail = 3'($urandom_range(7, 0));
    end else if (kind < 30 && len > 1) begin
      // one continuation byte inside the sequence with the wrong top bits
      pos = $urandom_range(len - 1, 1);
      do octet[pos] = 8'($urandom);
      while ((octet[pos] & utf8_dec_pkg::CONT_MASK) == utf8_dec_pkg::CONT_MATCH);
    end else if (kind < 42) begin
      avail = 3'($urandom_range(len - 1, 0));
    end
    return make_window(octet[0], octet[1], octet[2], octet[3], octet[4], octet[5],
                       avail);
  endfunction

  // smallest and largest payload for lengths 1, 2, 3 and 6, largest for 4 and 5
  task automatic test_well_formed_lengths();
    send_window(make_window(8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd1));
    send_window(make_window(8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd6));
    send_window(make_window(8'hc0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    send_window(make_window(8'hdf, 8'hbf, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    send_window(make_window(8'he0, 8'h80, 8'h80, 8'hff, 8'hff, 8'hff, 3'd6));
    send_window(make_window(8'hef, 8'hbf, 8'hbf, 8'h00, 8'h00, 8'h00, 3'd3));
    send_window(make_window(8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h00, 8'h00, 3'd4));
    send_window(make_window(8'hfb, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'h00, 3'd5));
    send_window(make_window(8'hfc, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    // largest code point, and a count of seven taken as six
    send_window(make_window(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd7));
  endtask

  // continuation bytes and the two bytes that never lead
  task automatic test_bad_lead_bytes();
    send_window(make_window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    send_window(make_window(8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd6));
    send_window(make_window(8'hfe, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd7));
    send_window(make_window(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd6));
  endtask

  // empty window and windows one byte short of the sequence
  task automatic test_short_windows();
    send_window(make_window(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
    send_window(make_window(8'hc2, 8'ha9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1));
    send_window(make_window(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 3'd5));
  endtask

  // first or last following byte not of the form 10xxxxxx
  task automatic test_bad_continuation();
    send_window(make_window(8'hc3, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 3'd2));
    send_window(make_window(8'he2, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
    send_window(make_window(8'hf0, 8'h90, 8'h80, 8'h7f, 8'h00, 8'h00, 3'd4));
    send_window(make_window(8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hc0, 3'd6));
  endtask

  task automatic test_random_windows(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_window(random_window());
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    window_valid <= 1'b0;
    window       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // light sender gaps, heavy receiver stalls
    send_idle_pct = 13;
    recv_idle_pct = 46;
    test_well_formed_lengths();
    test_bad_lead_bytes();
    test_short_windows();
    test_bad_continuation();
    test_random_windows(PHASE_ITEMS);

    // heavy sender gaps, light receiver stalls
    send_idle_pct = 46;
    recv_idle_pct = 13;
    test_random_windows(PHASE_ITEMS);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_windows(PHASE_ITEMS + 1);

    window_valid <= 1'b0;
    // wait out the pipeline, the watchdog bounds this
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_utf8_sequence_decoder_unit: clean");
    end else begin
      $display("tb_utf8_sequence_decoder_unit: errors");
    end
    $finish;
  end

endmodule
